@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `ASSERT_CLK(lbl, clk, rstn, !(expr), msg)
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ design/ufcr_pkg.sv @@
// ---------------------------------------------------------------------------
// ufcr_pkg
// Types, constants and the CRC-32 byte update of the frame checker.
// ---------------------------------------------------------------------------
package ufcr_pkg;

  localparam int unsigned PAYLOAD_BYTES = 8192;
  localparam int unsigned TRAILER_BYTES = 4;
  localparam int unsigned FRAME_LEN     = PAYLOAD_BYTES + TRAILER_BYTES;
  // Count saturates at FRAME_LEN + 1 (too long).
  localparam int unsigned CNT_W         = $clog2(FRAME_LEN + 2);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [7:0]  MAGIC_A  = 8'hAA;
  localparam logic [7:0]  MAGIC_B  = 8'h55;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_CRC_BAD = 2'd2;
  localparam logic [1:0] ST_LEN_BAD = 2'd3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_CRC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID = 2'd1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // What the back end has to emit for one queued job.
  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,  // header AA 55 id, then the payload byte
    KIND_DATA = 2'd1,  // payload byte
    KIND_BAD  = 2'd2,  // failed frame: one status result
    KIND_OK   = 2'd3   // good frame: CRC bytes and tail
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] data;    // payload byte in [7:0], or the final CRC
    logic [1:0]  status;  // failure code for KIND_BAD
  } job_t;

  // One reflected CRC-32 step over a byte.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/ufcr_front.sv @@
// ---------------------------------------------------------------------------
// ufcr_front
// Accept received bytes, track frame state and queue output jobs.
// ---------------------------------------------------------------------------
module ufcr_front import ufcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       check_crc_i,
  input  logic       take_i,     // item accepted this cycle
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [CNT_W-1:0] byte_count_q, byte_count_d;
  logic [31:0]      running_crc_q, running_crc_d;
  logic [31:0]      received_crc_q, received_crc_d;
  logic             header_sent_q, header_sent_d;

  logic [CNT_W-1:0] trailer_off;
  logic [31:0]      crc_final;

  assign trailer_off = byte_count_q - CNT_W'(PAYLOAD_BYTES);
  assign crc_final   = running_crc_q ^ CRC_ONES;

  always_comb begin
    byte_count_d   = byte_count_q;
    running_crc_d  = running_crc_q;
    received_crc_d = received_crc_q;
    header_sent_d  = header_sent_q;
    push_o         = 1'b0;
    job_o.kind     = KIND_DATA;
    job_o.data     = {24'd0, rx_byte_i};
    job_o.status   = ST_BUSY;
    if (take_i && !frame_end_i) begin
      if (byte_count_q < CNT_W'(PAYLOAD_BYTES)) begin
        push_o        = 1'b1;
        job_o.kind    = header_sent_q ? KIND_DATA : KIND_HDR;
        header_sent_d = 1'b1;
        running_crc_d = crc32_byte(running_crc_q, rx_byte_i);
      end else if (byte_count_q < CNT_W'(FRAME_LEN)) begin
        // Trailer: collect the received CRC, little-endian.
        received_crc_d = received_crc_q |
                         ({24'd0, rx_byte_i} << {trailer_off[1:0], 3'b000});
      end
      if (byte_count_q < CNT_W'(FRAME_LEN + 1)) begin
        byte_count_d = byte_count_q + CNT_W'(1);
      end
    end else if (take_i) begin
      push_o     = 1'b1;
      job_o.data = crc_final;
      if (byte_count_q != CNT_W'(FRAME_LEN)) begin
        job_o.kind   = KIND_BAD;
        job_o.status = ST_LEN_BAD;
      end else if (check_crc_i && (received_crc_q != crc_final)) begin
        job_o.kind   = KIND_BAD;
        job_o.status = ST_CRC_BAD;
      end else begin
        job_o.kind   = KIND_OK;
      end
      // Clear for the next frame.
      byte_count_d   = '0;
      running_crc_d  = CRC_ONES;
      received_crc_d = '0;
      header_sent_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      running_crc_q  <= CRC_ONES;
      received_crc_q <= '0;
      header_sent_q  <= 1'b0;
    end else begin
      byte_count_q   <= byte_count_d;
      running_crc_q  <= running_crc_d;
      received_crc_q <= received_crc_d;
      header_sent_q  <= header_sent_d;
    end
  end

endmodule

@@ design/ufcr_fifo.sv @@
// ---------------------------------------------------------------------------
// ufcr_fifo
// Short job queue between the front and back ends.
// ---------------------------------------------------------------------------
module ufcr_fifo import ufcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PTR_W+1)'(FIFO_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (PTR_W+1)'(1);
        2'b01:   count_q <= count_q - (PTR_W+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ design/ufcr_back.sv @@
// ---------------------------------------------------------------------------
// ufcr_back
// Expand queued jobs into output bytes through a registered output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ufcr_back import ufcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] source_id_i,
  input  job_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       last_o,
  output logic [1:0] status_o
);

  logic [2:0] step_q, step_d;
  logic [2:0] last_step;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       byte_valid_q, byte_valid_d;
  logic       last_q, last_d;
  logic [1:0] status_q, status_d;
  logic       load;
  logic [31:0] crc_shift;

  assign crc_shift = head_i.data >> {step_q[1:0], 3'b000};

  always_comb begin
    case (head_i.kind)
      KIND_HDR: last_step = 3'd3;
      KIND_OK:  last_step = 3'd5;
      default:  last_step = 3'd0;
    endcase
  end

  // Load the output register when a job is queued and the register is empty or being taken.
  assign load  = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && (step_q == last_step);

  always_comb begin
    out_byte_d   = 8'd0;
    byte_valid_d = 1'b1;
    last_d       = 1'b0;
    status_d     = ST_BUSY;
    case (head_i.kind)
      KIND_HDR: begin
        case (step_q)
          3'd0:    out_byte_d = MAGIC_A;
          3'd1:    out_byte_d = MAGIC_B;
          3'd2:    out_byte_d = source_id_i;
          default: out_byte_d = head_i.data[7:0];
        endcase
      end
      KIND_DATA: out_byte_d = head_i.data[7:0];
      KIND_BAD: begin
        byte_valid_d = 1'b0;
        last_d       = 1'b1;
        status_d     = head_i.status;
      end
      KIND_OK: begin
        if (step_q == 3'd4) begin
          out_byte_d = MAGIC_B;
        end else if (step_q == 3'd5) begin
          out_byte_d = MAGIC_A;
          last_d     = 1'b1;
          status_d   = ST_OK;
        end else begin
          out_byte_d = crc_shift[7:0];
        end
      end
      default: out_byte_d = 8'd0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    step_d      = step_q;
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = pop_o ? 3'd0 : step_q + 3'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      last_q       <= last_d;
      status_q     <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign last_o       = last_q;
  assign status_o     = status_q;

  // A job in the middle of expansion stays at the head of the queue.
  `ASSERT_CLK(a_step_holds_job, clk_i, rst_ni, (step_q != 3'd0) |-> !empty_i,
              "job left the queue before it was fully expanded")
  // Status is reported on the last result of a frame only.
  `ASSERT_CLK(a_status_on_last, clk_i, rst_ni,
              out_valid_q |-> ((status_q != ST_BUSY) == last_q),
              "frame status and last flag disagree")
  // A result without a byte is always a failed frame's only result.
  `ASSERT_CLK(a_novalid_is_fail, clk_i, rst_ni,
              (out_valid_q && !byte_valid_q) |->
                (last_q && out_byte_q == 8'd0 &&
                 (status_q == ST_CRC_BAD || status_q == ST_LEN_BAD)),
              "empty result is not a failure report")
  // The step counter stays inside the current job's range.
  `ASSERT_NEVER(a_step_range, clk_i, rst_ni, !empty_i && (step_q > last_step),
                "step counter ran past the job")

endmodule

@@ design/uart_frame_crc_check_and_reframe.sv @@
// ---------------------------------------------------------------------------
// uart_frame_crc_check_and_reframe
// Serial frame CRC-32 checker and reframer.
// ---------------------------------------------------------------------------
// Received bytes enter on the slave stream while it is ready; an item with
// tlast high is the end-of-reception marker and its tdata is ignored. Each
// frame is PAYLOAD_BYTES payload bytes plus a 4-byte little-endian CRC-32
// (reflected, poly 0xEDB88320, init and final xor all ones). Payload bytes
// are forwarded at once, the first one preceded by the header AA 55
// source_id; received CRC bytes are kept and not forwarded, and bytes past
// the frame are dropped. At the marker the length and, with check_crc set,
// the CRC are checked: a good frame ends with the computed CRC (LSB first),
// 55 and AA, the last carrying tlast and status ok; a failed frame gives a
// single result with no byte, tlast and status crc mismatch or bad length.
// Downstream must drop any frame whose final status is not ok. The front
// end takes one input item per cycle while the four-entry job queue has
// room; the back end, unless stalled, emits one result per cycle: one per
// payload byte, four for the first, one (failure) or six (good frame) for
// the marker. The output port, one result per cycle while ready, sets the
// sustained rate. The user writes configuration (index 0 check_crc, index 1
// source_id) through cfg_we_i while the block is idle; it is not enforced.
module uart_frame_crc_check_and_reframe import ufcr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  // Received byte stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  input  logic                 s_axis_tlast,   // frame_end
  // Output frame stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] out_byte
  output logic                 m_axis_tlast,   // last_of_frame
  output logic [2:0]           m_axis_tuser    // [0] byte_valid, [2:1] frame_status
);

  logic       check_crc_q;
  logic [7:0] source_id_q;

  logic       take;
  logic       push;
  job_t       push_job;
  job_t       head;
  logic       pop;
  logic       empty;
  logic       full;
  logic       byte_valid;
  logic [1:0] frame_status;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_crc_q <= 1'b0;
      source_id_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHECK_CRC: check_crc_q <= cfg_wdata_i[0];
        CFG_SOURCE_ID: source_id_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Accept whenever the job queue has room; every item then fits.
  assign s_axis_tready = !full;
  assign take          = s_axis_tvalid && !full;

  ufcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .check_crc_i (check_crc_q),
    .take_i      (take),
    .rx_byte_i   (s_axis_tdata),
    .frame_end_i (s_axis_tlast),
    .push_o      (push),
    .job_o       (push_job)
  );

  ufcr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  ufcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .source_id_i  (source_id_q),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .byte_valid_o (byte_valid),
    .last_o       (m_axis_tlast),
    .status_o     (frame_status)
  );

  assign m_axis_tuser = {frame_status, byte_valid};

endmodule
